// ===== hdl/gfr_pkg.sv =====
// Shared types and constants of the glyph framebuffer renderer.
`default_nettype none
package gfr_pkg;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_CHAR   = 3'd0,
    MODE_CURSOR = 3'd1,
    MODE_PIXEL  = 3'd2,
    MODE_FILL   = 3'd3,
    MODE_READ   = 3'd4,
    MODE_GLYPH  = 3'd5,
    MODE_RSVD6  = 3'd6,
    MODE_RSVD7  = 3'd7
  } mode_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_INVERT       = 2'd2;

  // Printable character range.
  localparam logic [7:0] FIRST_CHAR = 8'd32;
  localparam logic [7:0] LAST_CHAR  = 8'd126;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GMOD,
    ST_CMOD,
    ST_CROW,
    ST_CLAT,
    ST_CPR,
    ST_CPW,
    ST_PR,
    ST_PW,
    ST_FILL,
    ST_RDW,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/gfr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/glyph_framebuffer_renderer.sv =====
// Top level of the monochrome page-ordered framebuffer and text renderer.
// Each word on the input channel performs one operation and returns one result word.
// Items are processed one at a time by a sequencer around a frame RAM and a glyph RAM.
// A pixel draw and each pixel of a character are a read-modify-write through the single
// frame RAM port pair; a glyph load and a character first fold the glyph address into
// the glyph store by repeated subtraction of GLYPH_ROWS, and fill sweeps every frame
// byte. After reset a clearing pass zeroes the frame RAM before the first word is taken.
`default_nettype none
module glyph_framebuffer_renderer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_ROWS    = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  x_pos_i,
  input  wire logic [7:0]  y_pos_i,
  input  wire logic        color_i,
  input  wire logic [11:0] address_i,
  input  wire logic [15:0] row_bits_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [7:0]       read_byte_o
);

  localparam int FRAME_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int FA_W        = $clog2(FRAME_BYTES);
  localparam int GA_W        = $clog2(GLYPH_ROWS);

  gfr_pkg::state_e state_q, state_d;

  logic [4:0]      gw_q;
  logic [5:0]      gh_q;
  logic            inv_q;
  logic [8:0]      cur_x_q;
  logic [7:0]      cur_y_q;
  gfr_pkg::mode_e  op_q;
  logic            col_q;
  logic [12:0]     tmp_q;
  logic [GA_W-1:0] gidx_q;
  logic [15:0]     row_q;
  logic [15:0]     wbits_q;
  logic [5:0]      i_q;
  logic [4:0]      j_q;
  logic [7:0]      px_q;
  logic [7:0]      py_q;
  logic [FA_W-1:0] cnt_q;
  logic [7:0]      fill_q;
  logic            res_ok_q;
  logic [7:0]      res_byte_q;
  logic            out_valid_q;
  logic            out_ok_q;
  logic [7:0]      out_byte_q;

  logic            accept;
  logic            in_range;
  logic            fits;
  logic [6:0]      cidx;
  logic [12:0]     base;
  logic            tmp_ge;
  logic [16:0]     pa_full;
  logic [FA_W-1:0] pix_addr;
  logic            pix_color;
  logic [7:0]      bit_mask;
  logic [7:0]      f_rdata;
  logic [15:0]     g_rdata;
  logic            f_we;
  logic [FA_W-1:0] f_waddr;
  logic [7:0]      f_wdata;
  logic [FA_W-1:0] f_raddr;
  logic            g_we;
  logic            last_col;
  logic            last_row;
  logic            out_free;
  logic [GA_W:0]   gidx_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != gfr_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_ok_q;
  assign read_byte_o = out_byte_q;

  // Admission checks for characters and pixels.
  assign in_range = ({1'b0, x_pos_i} < 9'(SCREEN_WIDTH)) && ({1'b0, y_pos_i} < 9'(SCREEN_HEIGHT));
  assign fits     = ((10'(cur_x_q) + 10'(gw_q)) <= 10'(SCREEN_WIDTH)) &&
                    ((9'(cur_y_q) + 9'(gh_q)) <= 9'(SCREEN_HEIGHT));
  assign cidx     = 7'(char_code_i - gfr_pkg::FIRST_CHAR);
  assign base     = {6'd0, cidx} * {7'd0, gh_q};
  assign tmp_ge   = {1'b0, tmp_q} >= 14'(GLYPH_ROWS);
  assign gidx_inc = {1'b0, gidx_q} + 1'b1;
  assign last_col = (j_q == gw_q - 5'd1);
  assign last_row = (i_q == gh_q - 6'd1);

  // Page-ordered byte address and bit of the current pixel.
  assign pa_full   = 17'(px_q) + 17'(py_q[7:3]) * 17'(SCREEN_WIDTH);
  assign pix_addr  = pa_full[FA_W-1:0];
  assign bit_mask  = 8'd1 << py_q[2:0];
  assign pix_color = ((op_q == gfr_pkg::MODE_CHAR) ? (row_q[15] ? col_q : !col_q) : col_q)
                     ^ inv_q;

  // Frame RAM port control.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = pix_addr;
    f_wdata = pix_color ? (f_rdata | bit_mask) : (f_rdata & ~bit_mask);
    f_raddr = pix_addr;
    if (state_q == gfr_pkg::ST_CLEAR || state_q == gfr_pkg::ST_FILL) begin
      f_we    = 1'b1;
      f_waddr = cnt_q;
      f_wdata = fill_q;
    end else if (state_q == gfr_pkg::ST_CPW || state_q == gfr_pkg::ST_PW) begin
      f_we = 1'b1;
    end
    if (state_q == gfr_pkg::ST_IDLE) begin
      f_raddr = FA_W'(address_i);
    end
  end

  assign g_we = (state_q == gfr_pkg::ST_GMOD) && !tmp_ge;

  gfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  gfr_ram #(.WIDTH(16), .DEPTH(GLYPH_ROWS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (tmp_q[GA_W-1:0]),
    .wdata_i (wbits_q),
    .raddr_i (gidx_q),
    .rdata_o (g_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfr_pkg::ST_CLEAR: begin
        if (cnt_q == FA_W'(FRAME_BYTES - 1)) state_d = gfr_pkg::ST_IDLE;
      end
      gfr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (gfr_pkg::mode_e'(mode_i))
            gfr_pkg::MODE_CHAR: begin
              if (char_code_i >= gfr_pkg::FIRST_CHAR && char_code_i <= gfr_pkg::LAST_CHAR &&
                  fits) begin
                state_d = gfr_pkg::ST_CMOD;
              end else begin
                state_d = gfr_pkg::ST_DONE;
              end
            end
            gfr_pkg::MODE_PIXEL: state_d = in_range ? gfr_pkg::ST_PR : gfr_pkg::ST_DONE;
            gfr_pkg::MODE_FILL:  state_d = gfr_pkg::ST_FILL;
            gfr_pkg::MODE_READ: begin
              state_d = ({2'b0, address_i} < 14'(FRAME_BYTES)) ? gfr_pkg::ST_RDW
                                                                : gfr_pkg::ST_DONE;
            end
            gfr_pkg::MODE_GLYPH: state_d = gfr_pkg::ST_GMOD;
            default:             state_d = gfr_pkg::ST_DONE;
          endcase
        end
      end
      gfr_pkg::ST_GMOD: if (!tmp_ge) state_d = gfr_pkg::ST_DONE;
      gfr_pkg::ST_CMOD: begin
        if (!tmp_ge) begin
          state_d = (gw_q == 5'd0 || gh_q == 6'd0) ? gfr_pkg::ST_DONE : gfr_pkg::ST_CROW;
        end
      end
      gfr_pkg::ST_CROW: state_d = gfr_pkg::ST_CLAT;
      gfr_pkg::ST_CLAT: state_d = gfr_pkg::ST_CPR;
      gfr_pkg::ST_CPR:  state_d = gfr_pkg::ST_CPW;
      gfr_pkg::ST_CPW: begin
        if (!last_col)     state_d = gfr_pkg::ST_CPR;
        else if (last_row) state_d = gfr_pkg::ST_DONE;
        else               state_d = gfr_pkg::ST_CROW;
      end
      gfr_pkg::ST_PR:   state_d = gfr_pkg::ST_PW;
      gfr_pkg::ST_PW:   state_d = gfr_pkg::ST_DONE;
      gfr_pkg::ST_FILL: begin
        if (cnt_q == FA_W'(FRAME_BYTES - 1)) state_d = gfr_pkg::ST_DONE;
      end
      gfr_pkg::ST_RDW:  state_d = gfr_pkg::ST_DONE;
      gfr_pkg::ST_DONE: if (out_free) state_d = gfr_pkg::ST_IDLE;
      default:          state_d = gfr_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: configuration, cursor, sweep counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q        <= 5'd7;
      gh_q        <= 6'd10;
      inv_q       <= 1'b0;
      cur_x_q     <= 9'd0;
      cur_y_q     <= 8'd0;
      cnt_q       <= '0;
      fill_q      <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        priority case (cfg_index_i)
          gfr_pkg::CFG_GLYPH_WIDTH:  gw_q  <= cfg_data_i[4:0];
          gfr_pkg::CFG_GLYPH_HEIGHT: gh_q  <= cfg_data_i;
          gfr_pkg::CFG_INVERT:       inv_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept && gfr_pkg::mode_e'(mode_i) == gfr_pkg::MODE_CURSOR) begin
        cur_x_q <= {1'b0, x_pos_i};
        cur_y_q <= y_pos_i;
      end
      if (accept && gfr_pkg::mode_e'(mode_i) == gfr_pkg::MODE_FILL) begin
        cnt_q  <= '0;
        fill_q <= {8{color_i}};
      end else if (state_q == gfr_pkg::ST_CLEAR || state_q == gfr_pkg::ST_FILL) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // The cursor steps right after the last pixel of a glyph, or for an empty glyph.
      if ((state_q == gfr_pkg::ST_CPW && last_col && last_row) ||
          (state_q == gfr_pkg::ST_CMOD && !tmp_ge && (gw_q == 5'd0 || gh_q == 6'd0))) begin
        cur_x_q <= cur_x_q + 9'(gw_q);
      end
      if (state_q == gfr_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= gfr_pkg::mode_e'(mode_i);
      col_q      <= color_i;
      px_q       <= x_pos_i;
      py_q       <= y_pos_i;
      wbits_q    <= row_bits_i;
      i_q        <= 6'd0;
      res_byte_q <= 8'h00;
      tmp_q      <= (gfr_pkg::mode_e'(mode_i) == gfr_pkg::MODE_GLYPH) ? {1'b0, address_i}
                                                                      : base;
      unique case (gfr_pkg::mode_e'(mode_i))
        gfr_pkg::MODE_CURSOR, gfr_pkg::MODE_PIXEL, gfr_pkg::MODE_FILL,
        gfr_pkg::MODE_GLYPH: res_ok_q <= 1'b1;
        gfr_pkg::MODE_CHAR:  res_ok_q <= (char_code_i >= gfr_pkg::FIRST_CHAR) &&
                                         (char_code_i <= gfr_pkg::LAST_CHAR) && fits;
        gfr_pkg::MODE_READ:  res_ok_q <= ({2'b0, address_i} < 14'(FRAME_BYTES));
        default:             res_ok_q <= 1'b0;
      endcase
    end
    // Fold the glyph index into the store by repeated subtraction.
    if ((state_q == gfr_pkg::ST_GMOD || state_q == gfr_pkg::ST_CMOD) && tmp_ge) begin
      tmp_q <= 13'({1'b0, tmp_q} - 14'(GLYPH_ROWS));
    end
    if (state_q == gfr_pkg::ST_CMOD && !tmp_ge) begin
      gidx_q <= tmp_q[GA_W-1:0];
    end
    // Latch a glyph row and start its pixel walk.
    if (state_q == gfr_pkg::ST_CLAT) begin
      row_q <= g_rdata;
      j_q   <= 5'd0;
      px_q  <= cur_x_q[7:0];
      py_q  <= cur_y_q + 8'(i_q);
    end
    if (state_q == gfr_pkg::ST_CPW) begin
      row_q <= {row_q[14:0], 1'b0};
      j_q   <= j_q + 5'd1;
      px_q  <= px_q + 8'd1;
      if (last_col) begin
        i_q    <= i_q + 6'd1;
        gidx_q <= (gidx_inc == (GA_W+1)'(GLYPH_ROWS)) ? '0 : gidx_inc[GA_W-1:0];
      end
    end
    if (state_q == gfr_pkg::ST_RDW) begin
      res_byte_q <= f_rdata;
    end
    if (state_q == gfr_pkg::ST_DONE && out_free) begin
      out_ok_q   <= res_ok_q;
      out_byte_q <= res_byte_q;
    end
  end

`ifndef NO_ASSERTIONS
  // The clearing pass runs only once after reset.
  a_no_reclear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != gfr_pkg::ST_CLEAR |=> state_q != gfr_pkg::ST_CLEAR)
    else $error("frame clearing pass restarted");

  // A character pixel always lands inside the frame.
  a_char_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gfr_pkg::ST_CPW |-> pa_full < 17'(FRAME_BYTES))
    else $error("character pixel outside the frame");

  // The glyph row index stays inside the glyph store.
  a_gidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gfr_pkg::ST_CROW |-> {1'b0, gidx_q} < (GA_W+1)'(GLYPH_ROWS))
    else $error("glyph index out of range");

  // A result word is presented only after the sequencer finishes an item.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == gfr_pkg::ST_DONE)
    else $error("result word without a finished item");
`endif

endmodule
`default_nettype wire

// ===== bench/glyph_framebuffer_renderer_test.sv =====
// Self-checking testbench for the glyph framebuffer renderer.
`timescale 1ns / 100ps
module glyph_framebuffer_renderer_test;

  localparam int SCREEN_W   = 128;
  localparam int SCREEN_H   = 64;
  localparam int GLYPH_N    = 4096;
  localparam int FRAME_SIZE = SCREEN_W * ((SCREEN_H + 7) / 8);

  typedef struct {
    gfr_pkg::mode_e mode;
    logic [7:0]     code;
    logic [7:0]     x;
    logic [7:0]     y;
    logic           color;
    logic [11:0]    addr;
    logic [15:0]    bits;
  } op_t;

  typedef struct {
    logic       ok;
    logic [7:0] data;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [5:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  mode_i;
  logic [7:0]  char_code_i;
  logic [7:0]  x_pos_i;
  logic [7:0]  y_pos_i;
  logic        color_i;
  logic [11:0] address_i;
  logic [15:0] row_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        accepted_o;
  logic [7:0]  read_byte_o;

  glyph_framebuffer_renderer DUT (.*);

  // Operations waiting to be sent, and answers waiting to come back.
  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      errors;
  int      words_sent;

  // Shadow state of the renderer.
  bit [7:0]  frame_mem[FRAME_SIZE];
  bit [15:0] glyph_mem[GLYPH_N];
  bit [8:0]  cur_x;
  bit [7:0]  cur_y;
  int        cfg_w;
  int        cfg_h;
  bit        cfg_inv;

  // Stimulus side bookkeeping of which glyph rows hold data.
  bit        row_loaded[GLYPH_N];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Set or clear one pixel, honoring the invert register.
  task automatic plot(input int px, input int py, input bit c);
    int idx;
    if (px >= SCREEN_W || py >= SCREEN_H) return;
    idx = px + (py / 8) * SCREEN_W;
    frame_mem[idx][py % 8] = c ^ cfg_inv;
  endtask

  // Apply one operation to the shadow state and return its answer.
  task automatic render_op(input op_t op, output answer_t ans);
    bit [15:0] row;
    bit        b;
    ans.ok   = 1'b0;
    ans.data = 8'd0;
    case (op.mode)
      gfr_pkg::MODE_CHAR: begin
        if (op.code >= gfr_pkg::FIRST_CHAR && op.code <= gfr_pkg::LAST_CHAR &&
            int'(cur_x) + cfg_w <= SCREEN_W && int'(cur_y) + cfg_h <= SCREEN_H) begin
          for (int i = 0; i < cfg_h; i++) begin
            row = glyph_mem[((int'(op.code) - 32) * cfg_h + i) % GLYPH_N];
            for (int j = 0; j < cfg_w; j++) begin
              b = (j < 16) ? row[15 - j] : 1'b0;
              plot(int'(cur_x) + j, int'(cur_y) + i, b ? op.color : ~op.color);
            end
          end
          cur_x  = cur_x + 9'(cfg_w);
          ans.ok = 1'b1;
        end
      end
      gfr_pkg::MODE_CURSOR: begin
        cur_x  = {1'b0, op.x};
        cur_y  = op.y;
        ans.ok = 1'b1;
      end
      gfr_pkg::MODE_PIXEL: begin
        plot(op.x, op.y, op.color);
        ans.ok = 1'b1;
      end
      gfr_pkg::MODE_FILL: begin
        foreach (frame_mem[i]) frame_mem[i] = op.color ? 8'hFF : 8'h00;
        ans.ok = 1'b1;
      end
      gfr_pkg::MODE_READ: begin
        if (op.addr < FRAME_SIZE) begin
          ans.data = frame_mem[op.addr];
          ans.ok   = 1'b1;
        end
      end
      gfr_pkg::MODE_GLYPH: begin
        glyph_mem[op.addr % GLYPH_N] = op.bits;
        ans.ok = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Queue an operation; a printable character first gets its glyph rows loaded.
  task automatic queue_op(input gfr_pkg::mode_e m, input int code, input int x, input int y,
                          input int c, input int addr, input int bits);
    op_t op;
    int  r;
    if (m == gfr_pkg::MODE_CHAR && code >= 32 && code <= 126) begin
      for (int i = 0; i < cfg_h; i++) begin
        r = ((code - 32) * cfg_h + i) % GLYPH_N;
        if (!row_loaded[r])
          queue_op(gfr_pkg::MODE_GLYPH, 0, 0, 0, 0, r, $urandom_range(0, 65535));
      end
    end
    if (m == gfr_pkg::MODE_GLYPH) row_loaded[addr % GLYPH_N] = 1'b1;
    op.mode  = m;
    op.code  = 8'(code);
    op.x     = 8'(x);
    op.y     = 8'(y);
    op.color = 1'(c);
    op.addr  = 12'(addr);
    op.bits  = 16'(bits);
    pending_ops.push_back(op);
  endtask

  // Write one register and mirror it in the shadow state.
  task automatic write_reg(input logic [1:0] idx, input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 6'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      gfr_pkg::CFG_GLYPH_WIDTH:  cfg_w = value;
      gfr_pkg::CFG_GLYPH_HEIGHT: cfg_h = value;
      default:                   cfg_inv = value[0];
    endcase
  endtask

  // Wait until every queued word has been sent and answered.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || expected_answers.size() != 0);
  endtask

  // Random traffic, weighted toward cursor-then-text sequences.
  task automatic random_ops(input int count);
    int r;
    int n;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 9) == 0)
          queue_op(gfr_pkg::MODE_CURSOR, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                   0, 0, 0);
        else
          queue_op(gfr_pkg::MODE_CURSOR, 0, $urandom_range(0, SCREEN_W - cfg_w),
                   $urandom_range(0, SCREEN_H - cfg_h), 0, 0, 0);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          queue_op(gfr_pkg::MODE_CHAR, $urandom_range(32, 126), 0, 0,
                   $urandom_range(0, 1), 0, 0);
      end else if (r < 55) begin
        queue_op(gfr_pkg::MODE_PIXEL, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 1), 0, 0);
      end else if (r < 70) begin
        queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, ($urandom_range(0, 4) == 0) ?
                 $urandom_range(0, 4095) : $urandom_range(0, FRAME_SIZE - 1), 0);
      end else if (r < 80) begin
        queue_op(gfr_pkg::MODE_GLYPH, 0, 0, 0, 0, $urandom_range(0, 4095),
                 $urandom_range(0, 65535));
      end else if (r < 82) begin
        queue_op(gfr_pkg::MODE_FILL, 0, 0, 0, $urandom_range(0, 1), 0, 0);
      end else if (r < 90) begin
        queue_op(gfr_pkg::MODE_CURSOR, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                 0, 0, 0);
      end else if (r < 96) begin
        queue_op(gfr_pkg::MODE_CHAR, $urandom_range(0, 255), 0, 0, $urandom_range(0, 1),
                 0, 0);
      end else begin
        queue_op(gfr_pkg::mode_e'($urandom_range(6, 7)), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 4095), $urandom_range(0, 65535));
      end
    end
  endtask

  // Drive the input channel and predict each accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    op_t     op;
    answer_t ans;
    int      idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        op.mode  = gfr_pkg::mode_e'(mode_i);
        op.code  = char_code_i;
        op.x     = x_pos_i;
        op.y     = y_pos_i;
        op.color = color_i;
        op.addr  = address_i;
        op.bits  = row_bits_i;
        render_op(op, ans);
        expected_answers.push_back(ans);
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        idle_pct = (words_sent < 600) ? 18 : (words_sent < 1200) ? 60 : 0;
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          op = pending_ops.pop_front();
          in_valid_i  <= 1'b1;
          mode_i      <= op.mode;
          char_code_i <= op.code;
          x_pos_i     <= op.x;
          y_pos_i     <= op.y;
          color_i     <= op.color;
          address_i   <= op.addr;
          row_bits_i  <= op.bits;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Stall the output channel at random and check each answer.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t ans;
    int      stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_answers.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          ans = expected_answers.pop_front();
          if (accepted_o !== ans.ok)
            report($sformatf("accepted %b, expected %b", accepted_o, ans.ok));
          if (read_byte_o !== ans.data)
            report($sformatf("read_byte %h, expected %h", read_byte_o, ans.data));
        end
      end
      stall_pct = (words_sent < 600) ? 60 : (words_sent < 1200) ? 18 : 0;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    errors      = 0;
    words_sent  = 0;
    cur_x       = '0;
    cur_y       = '0;
    cfg_w       = 7;
    cfg_h       = 10;
    cfg_inv     = 1'b0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = '0;
    char_code_i = '0;
    x_pos_i     = '0;
    y_pos_i     = '0;
    color_i     = 1'b0;
    address_i   = '0;
    row_bits_i  = '0;
    out_stall_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, frame edges, character bounds, unused modes.
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, FRAME_SIZE - 1, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, FRAME_SIZE, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, 4095, 0);
    queue_op(gfr_pkg::MODE_GLYPH, 0, 0, 0, 0, 4095, 16'hFFFF);
    queue_op(gfr_pkg::MODE_PIXEL, 0, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_PIXEL, 0, SCREEN_W - 1, SCREEN_H - 1, 1, 0, 0);
    queue_op(gfr_pkg::MODE_PIXEL, 0, SCREEN_W, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_PIXEL, 0, 255, 255, 1, 0, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, FRAME_SIZE - 1, 0);
    queue_op(gfr_pkg::MODE_CHAR, 32, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 126, 0, 0, 0, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 31, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 127, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 0, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 255, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CURSOR, 0, SCREEN_W - 6, 0, 0, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 65, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_CURSOR, 0, SCREEN_W - 7, SCREEN_H - 10, 0, 0, 0);
    queue_op(gfr_pkg::MODE_CHAR, 66, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, FRAME_SIZE - 1, 0);
    queue_op(gfr_pkg::MODE_FILL, 0, 0, 0, 1, 0, 0);
    queue_op(gfr_pkg::MODE_READ, 0, 0, 0, 0, 5, 0);
    queue_op(gfr_pkg::MODE_RSVD6, 0, 0, 0, 0, 0, 0);
    queue_op(gfr_pkg::MODE_RSVD7, 0, 0, 0, 0, 0, 0);
    queue_op(gfr_pkg::MODE_FILL, 0, 0, 0, 0, 0, 0);
    drain();

    // Smallest glyphs with inverted colors.
    write_reg(gfr_pkg::CFG_GLYPH_WIDTH, 1);
    write_reg(gfr_pkg::CFG_GLYPH_HEIGHT, 1);
    write_reg(gfr_pkg::CFG_INVERT, 1);
    random_ops(120);
    drain();

    // Large glyphs; few words since each character needs many glyph rows.
    write_reg(gfr_pkg::CFG_GLYPH_WIDTH, 16);
    write_reg(gfr_pkg::CFG_GLYPH_HEIGHT, 32);
    write_reg(gfr_pkg::CFG_INVERT, 0);
    random_ops(5);
    drain();

    write_reg(gfr_pkg::CFG_GLYPH_WIDTH, 8);
    write_reg(gfr_pkg::CFG_GLYPH_HEIGHT, 8);
    write_reg(gfr_pkg::CFG_INVERT, 1);
    random_ops(40);
    drain();

    write_reg(gfr_pkg::CFG_GLYPH_WIDTH, 5);
    write_reg(gfr_pkg::CFG_GLYPH_HEIGHT, 12);
    write_reg(gfr_pkg::CFG_INVERT, 0);
    random_ops(40);
    drain();

    write_reg(gfr_pkg::CFG_GLYPH_WIDTH, $urandom_range(1, 16));
    write_reg(gfr_pkg::CFG_GLYPH_HEIGHT, $urandom_range(1, 16));
    write_reg(gfr_pkg::CFG_INVERT, $urandom_range(0, 1));
    random_ops(40);
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
